[design/mbrb_pkg.sv]
// Shared types and codes for the monochrome bitmap row blit unit.
`default_nettype none
package mbrb_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_WORDS_PER_ROW = 1'b0;
  localparam logic CFG_ROW_COUNT     = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [6:0]        x_pos;
    logic [4:0]        y_pos;
    logic [5:0]        draw_width;
    logic [5:0]        draw_height;
    logic [4:0]        row_index;
    logic [WORD_W-1:0] row_bits;
  } mbrb_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              row_written;
  } mbrb_out_t;

endpackage
`default_nettype wire

[design/mbrb_shift_unit.sv]
// Shared 32-bit shifter; shift amounts of 32 or more give zero.
`default_nettype none
module mbrb_shift_unit (
  input  wire logic [mbrb_pkg::WORD_W-1:0] value,
  input  wire logic [5:0]                  amount,
  input  wire logic                        left,
  output logic      [mbrb_pkg::WORD_W-1:0] result
);

  always_comb begin
    if (amount[5]) begin
      result = '0;
    end else if (left) begin
      result = value << amount[4:0];
    end else begin
      result = value >> amount[4:0];
    end
  end

endmodule
`default_nettype wire

[design/mbrb_store.sv]
// Pixel word store: one write port, one registered read port.
`default_nettype none
module mbrb_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [mbrb_pkg::WORD_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [mbrb_pkg::WORD_W-1:0] rdata
);

  logic [mbrb_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/mono_bitmap_row_blit_unit.sv]
// Monochrome bitmap row blit unit: 1-bpp word store with draw, clear and read items.
// One item at a time. A draw item passes accept, decode, then a shift step and a
// read-modify-write step per word touched (one word, or two when it spans two) on the
// single store port, then the result; a clipped-away draw, a read outside the buffer
// or command 3 goes from decode straight to the result, an in-range read through a
// read issue step. A clear item walks all MAX_ROWS*MAX_WORDS_PER_ROW store words, one
// word per cycle. After reset the same walk runs before the first item is taken;
// configuration writes are taken at any time. The result sits in an output register,
// so a new item is accepted while it waits to be taken.
`default_nettype none
module mono_bitmap_row_blit_unit #(
  parameter int MAX_WORDS_PER_ROW = 4,
  parameter int MAX_ROWS          = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [5:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mbrb_pkg::mbrb_in_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mbrb_pkg::mbrb_out_t      out_item
);

  localparam int DEPTH = MAX_WORDS_PER_ROW * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0] MAXW = 5'(MAX_WORDS_PER_ROW);
  localparam logic [8:0] MAXR = 9'(MAX_ROWS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_MERGE  = 3'd3;
  localparam logic [2:0] ST_RDISS  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]  state;
  logic [2:0]  words_cfg;
  logic [5:0]  rows_cfg;
  mbrb_pkg::mbrb_in_t item;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic [4:0]  lo;
  logic [5:0]  left_len;
  logic [5:0]  end0;
  logic [4:0]  right_len;
  logic        second;
  logic        draw_ok;
  logic        read_ok;
  logic        phase;
  logic [mbrb_pkg::WORD_W-1:0] data_sh;
  logic [AW-1:0] clr_cnt;
  logic        clr_item;

  // decode
  logic [4:0]  wpr;
  logic [8:0]  rows;
  logic [9:0]  total;
  logic [5:0]  w_sat;
  logic [5:0]  r_row;
  logic [9:0]  x_max_raw;
  logic [9:0]  x_max;
  logic [5:0]  room;
  logic [5:0]  left_len_c;
  logic        draw_ok_c;
  logic        read_ok_c;
  logic        second_c;
  logic [5:0]  mul_row;
  logic [AW-1:0] base;

  // shifter and store
  logic [mbrb_pkg::WORD_W-1:0] sh_value;
  logic [5:0]  sh_amount;
  logic        sh_left;
  logic [mbrb_pkg::WORD_W-1:0] sh_out;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [mbrb_pkg::WORD_W-1:0] mem_wdata;
  logic        mem_re;
  logic [AW-1:0] mem_raddr;
  logic [mbrb_pkg::WORD_W-1:0] mem_rdata;

  always_comb begin
    if (words_cfg == 3'd0) begin
      wpr = 5'd1;
    end else if ({2'b00, words_cfg} > MAXW) begin
      wpr = MAXW;
    end else begin
      wpr = {2'b00, words_cfg};
    end
    if (rows_cfg == 6'd0) begin
      rows = 9'd1;
    end else if ({3'b000, rows_cfg} > MAXR) begin
      rows = MAXR;
    end else begin
      rows = {3'b000, rows_cfg};
    end
    total      = {wpr, 5'b00000};
    w_sat      = (item.draw_width > 6'd32) ? 6'd32 : item.draw_width;
    r_row      = {1'b0, item.y_pos} + {1'b0, item.row_index};
    x_max_raw  = {3'b000, item.x_pos} + {4'b0000, w_sat};
    x_max      = (x_max_raw > total) ? total : x_max_raw;
    room       = 6'd32 - {1'b0, item.x_pos[4:0]};
    left_len_c = (w_sat < room) ? w_sat : room;
    draw_ok_c  = ({3'b000, item.x_pos} < total) && ({4'b0000, item.y_pos} < rows) &&
                 (item.draw_width != 6'd0) && ({1'b0, item.row_index} < item.draw_height) &&
                 ({3'b000, r_row} < rows);
    read_ok_c  = ({4'b0000, item.y_pos} < rows) && ({3'b000, item.x_pos[6:5]} < wpr);
    second_c   = (x_max[9:5] != {3'b000, item.x_pos[6:5]}) && (x_max[4:0] != 5'd0) &&
                 (left_len_c < 6'd32);
    mul_row    = (item.command == mbrb_pkg::CMD_READ) ? {1'b0, item.y_pos} : r_row;
    base       = AW'(mul_row) * AW'(wpr);
  end

  always_comb begin
    if (state == ST_SHIFT) begin
      sh_value  = item.row_bits;
      sh_amount = phase ? left_len : {1'b0, lo};
      sh_left   = phase;
    end else begin
      sh_value  = '1;
      sh_amount = phase ? {1'b0, right_len} : end0;
      sh_left   = 1'b0;
    end
  end

  mbrb_shift_unit u_shift (
    .value  (sh_value),
    .amount (sh_amount),
    .left   (sh_left),
    .result (sh_out)
  );

  always_comb begin
    mem_we    = (state == ST_MERGE) || (state == ST_CLEAR);
    mem_waddr = (state == ST_CLEAR) ? clr_cnt : (phase ? addr1 : addr0);
    mem_wdata = (state == ST_CLEAR) ? '0 : (mem_rdata | (data_sh & ~sh_out));
    mem_re    = (state == ST_SHIFT) || (state == ST_RDISS);
    mem_raddr = phase ? addr1 : addr0;
  end

  mbrb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      words_cfg <= 3'd4;
      rows_cfg  <= 6'd32;
      clr_cnt   <= '0;
      clr_item  <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index[0])
          mbrb_pkg::CFG_WORDS_PER_ROW: words_cfg <= cfg_data[2:0];
          mbrb_pkg::CFG_ROW_COUNT:     rows_cfg  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            if (in_item.command == mbrb_pkg::CMD_CLEAR) begin
              clr_item <= 1'b1;
              state    <= ST_CLEAR;
            end else begin
              state <= ST_DECODE;
            end
          end
        end
        ST_DECODE: begin
          addr0     <= base + AW'(item.x_pos[6:5]);
          addr1     <= base + AW'(x_max[9:5]);
          lo        <= item.x_pos[4:0];
          left_len  <= left_len_c;
          end0      <= {1'b0, item.x_pos[4:0]} + left_len_c;
          right_len <= x_max[4:0];
          second    <= second_c;
          draw_ok   <= draw_ok_c;
          read_ok   <= read_ok_c;
          phase     <= 1'b0;
          if (item.command == mbrb_pkg::CMD_DRAW && draw_ok_c) begin
            state <= ST_SHIFT;
          end else if (item.command == mbrb_pkg::CMD_READ && read_ok_c) begin
            state <= ST_RDISS;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SHIFT: begin
          data_sh <= sh_out;
          state   <= ST_MERGE;
        end
        ST_MERGE: begin
          if (!phase && second) begin
            phase <= 1'b1;
            state <= ST_SHIFT;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_RDISS: begin
          state <= ST_FINISH;
        end
        ST_CLEAR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            clr_cnt <= '0;
            state   <= clr_item ? ST_FINISH : ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + AW'(1);
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_item.read_data   <= (item.command == mbrb_pkg::CMD_READ && read_ok) ?
                                    mem_rdata : '0;
            out_item.row_written <= (item.command == mbrb_pkg::CMD_DRAW) && draw_ok;
            clr_item             <= 1'b0;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for mono_bitmap_row_blit_unit: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb;

  localparam int MAX_WPR = 4;
  localparam int MAX_ROWS = 32;
  localparam int STORE_WORDS = MAX_WPR * MAX_ROWS;
  localparam int PHASE_ITEMS = 212;
  localparam int NUM_PHASES = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    bit                   is_cfg;
    logic [5:0]           cfg_words;
    logic [5:0]           cfg_rows;
    mbrb_pkg::mbrb_in_t   item;
    bit                   typed;
    mbrb_pkg::mbrb_out_t  result;
  } step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  mbrb_pkg::mbrb_in_t   in_item = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  mbrb_pkg::mbrb_out_t  out_item;

  // predictor state
  logic [31:0] frame_words [STORE_WORDS];
  logic [2:0]  words_reg = 3'd4;
  logic [5:0]  rows_reg = 6'd32;

  mbrb_pkg::mbrb_out_t awaited_results [$];
  step_t       plan [$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  mono_bitmap_row_blit_unit #(
    .MAX_WORDS_PER_ROW(MAX_WPR),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int unsigned eff_words();
    if (words_reg == 0) return 1;
    if (words_reg > MAX_WPR) return MAX_WPR;
    return words_reg;
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  // MSB-first run of len ones starting first bits from the left
  function automatic logic [31:0] span_bits(input int unsigned first, input int unsigned len);
    logic [31:0] head;
    logic [31:0] tail;
    head = (first >= 32) ? 32'h0 : (32'hFFFF_FFFF >> first);
    tail = (first + len >= 32) ? 32'h0 : (32'hFFFF_FFFF >> (first + len));
    return head & ~tail;
  endfunction

  function automatic mbrb_pkg::mbrb_out_t blit_result(input mbrb_pkg::mbrb_in_t it);
    mbrb_pkg::mbrb_out_t res;
    int unsigned wpr, rows, total, w, r, x_end, lo, left_len, word, right_len;
    res = '0;
    wpr = eff_words();
    rows = eff_rows();
    total = wpr * 32;
    case (it.command)
      mbrb_pkg::CMD_CLEAR: begin
        for (int i = 0; i < STORE_WORDS; i++) frame_words[i] = '0;
      end
      mbrb_pkg::CMD_DRAW: begin
        w = (it.draw_width > 32) ? 32 : it.draw_width;
        r = it.y_pos + it.row_index;
        if (it.x_pos < total && it.y_pos < rows && w != 0 &&
            it.row_index < it.draw_height && r < rows) begin
          x_end = it.x_pos + w;
          if (x_end > total) x_end = total;
          word = it.x_pos >> 5;
          lo = it.x_pos & 31;
          left_len = 32 - lo;
          if (w < left_len) left_len = w;
          frame_words[r * wpr + word] |= (it.row_bits >> lo) & span_bits(lo, left_len);
          right_len = x_end & 31;
          if ((x_end >> 5) != word && right_len != 0 && left_len < 32)
            frame_words[r * wpr + (x_end >> 5)] |=
              (it.row_bits << left_len) & span_bits(0, right_len);
          res.row_written = 1'b1;
        end
      end
      mbrb_pkg::CMD_READ: begin
        if (it.y_pos < rows && (it.x_pos >> 5) < wpr)
          res.read_data = frame_words[it.y_pos * wpr + (it.x_pos >> 5)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic mbrb_pkg::mbrb_in_t rand_item();
    mbrb_pkg::mbrb_in_t it;
    int unsigned pick, wpr, rows;
    wpr = eff_words();
    rows = eff_rows();
    pick = $urandom_range(99);
    it.command = (pick < 2) ? mbrb_pkg::CMD_CLEAR : (pick < 5) ? CMD_UNUSED :
                 (pick < 40) ? mbrb_pkg::CMD_READ : mbrb_pkg::CMD_DRAW;
    it.x_pos = 7'($urandom_range(127));
    it.y_pos = 5'($urandom_range(31));
    it.draw_width = 6'($urandom_range(63));
    it.draw_height = 6'($urandom_range(63));
    it.row_index = 5'($urandom_range(31));
    it.row_bits = ($urandom_range(1) == 1) ? $urandom : ($urandom & $urandom);
    // mostly in-buffer reads and draws that land; the rest stays raw noise
    if ($urandom_range(9) != 0) begin
      it.x_pos = 7'($urandom_range(wpr * 32 - 1));
      it.y_pos = 5'($urandom_range(rows - 1));
      if (it.command == mbrb_pkg::CMD_DRAW) begin
        it.draw_width = 6'($urandom_range(32, 1));
        it.draw_height = 6'($urandom_range(32, 1));
        it.row_index = 5'($urandom_range(rows - 1 - it.y_pos));
        if (it.row_index >= it.draw_height)
          it.row_index = 5'($urandom_range(it.draw_height - 1));
      end
    end
    return it;
  endfunction

  function automatic void plan_item(input logic [1:0] cmd, input int x, y, w, h, p,
                                    input logic [31:0] bits, input bit typed,
                                    input logic [31:0] data, input bit wr);
    step_t s;
    s = '0;
    s.item.command = cmd;
    s.item.x_pos = 7'(x);
    s.item.y_pos = 5'(y);
    s.item.draw_width = 6'(w);
    s.item.draw_height = 6'(h);
    s.item.row_index = 5'(p);
    s.item.row_bits = bits;
    s.typed = typed;
    s.result.read_data = data;
    s.result.row_written = wr;
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(input logic [5:0] words, input logic [5:0] rows);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_words = words;
    s.cfg_rows = rows;
    plan.push_back(s);
  endfunction

  task automatic send_item(input mbrb_pkg::mbrb_in_t it, input bit typed,
                           input mbrb_pkg::mbrb_out_t typed_res);
    mbrb_pkg::mbrb_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    res = blit_result(it);
    awaited_results.push_back(typed ? typed_res : res);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic set_config(input logic [5:0] words, input logic [5:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= mbrb_pkg::CFG_WORDS_PER_ROW;
    cfg_data <= words;
    @(posedge clk);
    cfg_index <= mbrb_pkg::CFG_ROW_COUNT;
    cfg_data <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
    words_reg = words[2:0];
    rows_reg = rows;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    mbrb_pkg::mbrb_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result item with none expected: read_data %h row_written %b",
               out_item.read_data, out_item.row_written);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
          error_count++;
        end
        if (out_item.row_written !== want.row_written) begin
          $error("row_written: expected %b, got %b", want.row_written, out_item.row_written);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (frame_words[i]) frame_words[i] = '0;

    // default geometry: 4 words by 32 rows
    plan_item(mbrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
    plan_item(CMD_UNUSED, 127, 31, 63, 63, 31, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 0, 0, 32, 1, 0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1);
    plan_item(mbrb_pkg::CMD_READ, 0, 0, 0, 0, 0, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 5, 1, 0, 1, 0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 17, 3, 20, 2, 1, 32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 0, 4, 0, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 32, 4, 0, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 96, 5, 32, 1, 0, 32'hF0F0_F0F0, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 40, 6, 56, 1, 0, 32'hC3C3_C3C3, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 40, 7, 24, 1, 0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 64, 7, 0, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 120, 8, 32, 1, 0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 96, 8, 0, 0, 0, 32'h0, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 0, 9, 8, 2, 2, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 0, 31, 8, 32, 1, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 127, 31, 63, 63, 0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 96, 8, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
    // one word by two rows: starts past the edge, clip at column 32
    plan_cfg(6'd1, 6'd2);
    plan_item(mbrb_pkg::CMD_DRAW, 32, 0, 8, 1, 0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 0, 2, 8, 1, 0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_DRAW, 8, 0, 32, 2, 1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 32, 1, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);
    // zero in both registers acts as one
    plan_cfg(6'd0, 6'd0);
    plan_item(mbrb_pkg::CMD_DRAW, 0, 0, 4, 1, 0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0);
    plan_item(mbrb_pkg::CMD_READ, 0, 1, 0, 0, 0, 32'h0, 1'b1, 32'h0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        set_config(plan[i].cfg_words, plan[i].cfg_rows);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].result);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin set_config(6'd4, 6'd32); send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin set_config(6'd1, 6'd1);  send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin set_config(6'd2, 6'd17); send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin set_config(6'd0, 6'd0);  send_idle_pct = 14; recv_stall_pct = 14; end
        4: begin set_config(6'd7, 6'd63); send_idle_pct = 0;  recv_stall_pct = 0;  end
        5: begin set_config(6'd12, 6'd5); send_idle_pct = 86; recv_stall_pct = 0;  end
        6: begin set_config(6'd61, 6'd33); send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin set_config(6'd3, 6'd32); send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/mbrb_pkg.sv
design/mbrb_shift_unit.sv
design/mbrb_store.sv
design/mono_bitmap_row_blit_unit.sv
sim/tb.sv
